/* rtl/core/ihdp_pkg.sv */
// ----------------------------------------------------------------------------
// Image header dimension parser package
// Beat types, parser state, format codes and marker constants that are shared
// by the parse step and the top level.
// ----------------------------------------------------------------------------
package ihdp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        dims_valid;
    logic [1:0]  image_format;
    logic [31:0] natural_width;
    logic [31:0] natural_height;
  } out_beat_t;

  typedef enum logic [3:0] {
    PH_SNIFF,
    PH_PNG,
    PH_GIF,
    PH_JSIG,
    PH_JMARK,
    PH_JFILL,
    PH_JLENHI,
    PH_JLENLO,
    PH_JSKIP,
    PH_JSOF,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    FMT_NONE,
    FMT_PNG,
    FMT_GIF,
    FMT_JPEG
  } fmt_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  offset;
    logic [15:0] seg_left;
    logic [7:0]  len_hi;
    logic [7:0]  marker;
    fmt_t        fmt;
    logic [31:0] width;
    logic [31:0] height;
    logic        dims;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    phase:    PH_SNIFF,
    offset:   5'd0,
    seg_left: 16'd0,
    len_hi:   8'd0,
    marker:   8'd0,
    fmt:      FMT_NONE,
    width:    32'd0,
    height:   32'd0,
    dims:     1'b0
  };

  localparam logic [4:0] OFF_MAX = 5'd24;

  localparam logic [7:0] PNG_SIG [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };
  localparam logic [7:0] IHDR_TAG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

  localparam logic [7:0] GIF_G    = 8'h47;
  localparam logic [7:0] GIF_I    = 8'h49;
  localparam logic [7:0] GIF_F    = 8'h46;
  localparam logic [7:0] GIF_8    = 8'h38;
  localparam logic [7:0] GIF_7    = 8'h37;
  localparam logic [7:0] GIF_9    = 8'h39;
  localparam logic [7:0] GIF_A    = 8'h61;

  localparam logic [7:0] MK_FILL  = 8'hFF;
  localparam logic [7:0] MK_NONE  = 8'h00;
  localparam logic [7:0] MK_TEM   = 8'h01;
  localparam logic [7:0] MK_SOF_LO = 8'hC0;
  localparam logic [7:0] MK_SOF_HI = 8'hCF;
  localparam logic [7:0] MK_DHT   = 8'hC4;
  localparam logic [7:0] MK_JPG   = 8'hC8;
  localparam logic [7:0] MK_DAC   = 8'hCC;
  localparam logic [7:0] MK_RST0  = 8'hD0;
  localparam logic [7:0] MK_RST7  = 8'hD7;
  localparam logic [7:0] MK_SOI   = 8'hD8;
  localparam logic [7:0] MK_EOI   = 8'hD9;
  localparam logic [7:0] MK_SOS   = 8'hDA;

  function automatic logic is_sof(input logic [7:0] m);
    logic ok;
    ok = (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
         (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
    return ok;
  endfunction

  function automatic logic is_standalone(input logic [7:0] m);
    logic ok;
    ok = (m == MK_TEM) || (m == MK_SOI) || (m == MK_EOI) ||
         ((m >= MK_RST0) && (m <= MK_RST7));
    return ok;
  endfunction

endpackage

/* rtl/core/ihdp_step.sv */
// ----------------------------------------------------------------------------
// Image header parse step
// Applies one body byte to the parser state and forms the result that the
// final byte of a body reports. After the final byte the state returns to
// its reset value.
// ----------------------------------------------------------------------------
module ihdp_step (
  input  ihdp_pkg::parse_state_t cur,
  input  ihdp_pkg::in_beat_t     beat,
  output ihdp_pkg::parse_state_t state_nxt,
  output ihdp_pkg::out_beat_t    result
);
  import ihdp_pkg::*;

  parse_state_t upd;
  logic [7:0]   b;
  logic [4:0]   off;
  logic [15:0]  seg;
  logic [31:0]  height_shift;

  assign b            = beat.byte_value;
  assign off          = cur.offset;
  assign seg          = {cur.len_hi, b};
  assign height_shift = {cur.height[23:0], b};

  always_comb begin
    upd = cur;
    unique case (cur.phase)
      PH_SNIFF: begin
        if (b == PNG_SIG[0]) begin
          upd.phase = PH_PNG;
        end else if (b == GIF_G) begin
          upd.phase = PH_GIF;
        end else if (b == MK_FILL) begin
          upd.phase = PH_JSIG;
        end else begin
          upd.phase = PH_DONE;
        end
      end
      PH_PNG: begin
        if (off < 5'd8) begin
          if (b != PNG_SIG[off[2:0]]) begin
            upd.phase = PH_DONE;
          end else if (off == 5'd7) begin
            upd.fmt = FMT_PNG;
          end
        end else if (off < 5'd12) begin
          upd.phase = cur.phase;
        end else if (off < 5'd16) begin
          if (b != IHDR_TAG[off[1:0]]) begin
            upd.phase = PH_DONE;
          end
        end else if (off < 5'd20) begin
          upd.width = {cur.width[23:0], b};
        end else if (off < 5'd24) begin
          upd.height = height_shift;
          if (off == 5'd23) begin
            upd.dims  = (cur.width != 32'd0) && (height_shift != 32'd0);
            upd.phase = PH_DONE;
          end
        end else begin
          upd.phase = PH_DONE;
        end
      end
      PH_GIF: begin
        case (off)
          5'd1: if (b != GIF_I) upd.phase = PH_DONE;
          5'd2: if (b != GIF_F) upd.phase = PH_DONE;
          5'd3: if (b != GIF_8) upd.phase = PH_DONE;
          5'd4: if (b != GIF_7 && b != GIF_9) upd.phase = PH_DONE;
          5'd5: begin
            if (b != GIF_A) begin
              upd.phase = PH_DONE;
            end else begin
              upd.fmt = FMT_GIF;
            end
          end
          5'd6: upd.width = {24'd0, b};
          5'd7: upd.width[15:8] = b;
          5'd8: upd.height = {24'd0, b};
          5'd9: begin
            upd.height[15:8] = b;
            upd.dims         = 1'b1;
            upd.phase        = PH_DONE;
          end
          default: upd.phase = PH_DONE;
        endcase
      end
      PH_JSIG: begin
        if (off == 5'd1) begin
          if (b != MK_SOI) upd.phase = PH_DONE;
        end else if (off == 5'd2 && b == MK_FILL) begin
          upd.fmt   = FMT_JPEG;
          upd.phase = PH_JFILL;
        end else begin
          upd.phase = PH_DONE;
        end
      end
      PH_JMARK: begin
        upd.phase = (b == MK_FILL) ? PH_JFILL : PH_DONE;
      end
      PH_JFILL: begin
        if (b != MK_FILL) begin
          upd.marker = b;
          if (b == MK_NONE) begin
            upd.phase = PH_DONE;
          end else if (is_standalone(b)) begin
            upd.phase = PH_JMARK;
          end else if (b == MK_SOS) begin
            upd.phase = PH_DONE;
          end else begin
            upd.phase = PH_JLENHI;
          end
        end
      end
      PH_JLENHI: begin
        upd.len_hi = b;
        upd.phase  = PH_JLENLO;
      end
      PH_JLENLO: begin
        if (seg < 16'd2) begin
          upd.phase = PH_DONE;
        end else if (is_sof(cur.marker)) begin
          if (seg < 16'd8) begin
            upd.phase = PH_DONE;
          end else begin
            upd.seg_left = 16'd0;
            upd.phase    = PH_JSOF;
          end
        end else begin
          upd.seg_left = seg - 16'd2;
          upd.phase    = (seg == 16'd2) ? PH_JMARK : PH_JSKIP;
        end
      end
      PH_JSKIP: begin
        upd.seg_left = cur.seg_left - 16'd1;
        if (cur.seg_left == 16'd1) upd.phase = PH_JMARK;
      end
      PH_JSOF: begin
        upd.seg_left = cur.seg_left + 16'd1;
        case (cur.seg_left)
          16'd1: upd.height = {16'd0, b, 8'd0};
          16'd2: upd.height[7:0] = b;
          16'd3: upd.width = {16'd0, b, 8'd0};
          16'd4: begin
            upd.width[7:0] = b;
            upd.seg_left   = cur.seg_left;
            upd.dims       = 1'b1;
            upd.phase      = PH_DONE;
          end
          default: upd.seg_left = cur.seg_left + 16'd1;
        endcase
      end
      PH_DONE: upd.phase = PH_DONE;
      default: upd.phase = PH_DONE;
    endcase
    if (cur.offset < OFF_MAX) upd.offset = cur.offset + 5'd1;
  end

  always_comb begin
    result.dims_valid     = upd.dims;
    result.image_format   = upd.fmt;
    result.natural_width  = upd.dims ? upd.width : 32'd0;
    result.natural_height = upd.dims ? upd.height : 32'd0;
    state_nxt             = beat.last_byte ? ST_RESET : upd;
  end

endmodule

/* rtl/core/image_header_dimension_parser.sv */
// ----------------------------------------------------------------------------
// Image header dimension parser
// Sniffs PNG, GIF and JPEG signatures in a byte stream and reports the natural
// width and height of the image once per body, at the final byte.
//
//   channel | direction | payload     | beat
//   in_     | input     | in_beat_t   | one body byte, last_byte on the final
//   out_    | output    | out_beat_t  | one result per body
//
// One byte is taken every cycle while in_stall is low. A byte is registered on
// acceptance and applied to the parser state from that register; the result beat
// is registered when the final byte is applied, which a result-side stall can delay.
// rst_n clears the parser state and both valid flags.
// A stall on the result side holds back only a final byte; other bytes keep
// flowing while a finished result waits to be taken.
// ----------------------------------------------------------------------------
module image_header_dimension_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ihdp_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihdp_pkg::out_beat_t  out_data
);
  import ihdp_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  in_beat_t     s1_beat_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  out_beat_t    res;
  out_beat_t    out_beat_r;
  logic         out_valid_r, out_valid_nxt;
  logic         s1_go;
  logic         out_load;

  ihdp_step u_step (
    .cur       (st_r),
    .beat      (s1_beat_r),
    .state_nxt (st_nxt),
    .result    (res)
  );

  assign s1_go    = s1_valid_r && (!s1_beat_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign out_load = s1_go && s1_beat_r.last_byte;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) s1_valid_nxt = in_valid;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ST_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_beat_r <= in_data;
    if (out_load) out_beat_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

  a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_beat_r.last_byte |=> st_r.phase == PH_SNIFF && st_r.offset == 5'd0)
    else $error("parser state not cleared after the final byte");

  a_offset_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.offset <= OFF_MAX)
    else $error("byte offset passed its saturation point");

  a_dims_need_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dims |-> st_r.fmt != FMT_NONE)
    else $error("dimensions found without a recognized format");

  a_stall_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_beat_r.last_byte && out_valid_r)
    else $error("input stalled without a pending final byte");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("final byte produced no result beat");

endmodule

/* verif/ihdp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image header dimension checker
// Watches both channels of the parser. Every accepted byte beat is run through
// a local copy of the header parse, each final byte queues the result that
// the body should give, and each accepted result beat is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------
module ihdp_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ihdp_pkg::in_beat_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ihdp_pkg::out_beat_t  out_data,
  output int                   mismatches,
  output int                   dims_pending,
  output int                   results_checked,
  output int                   dims_reported
);
  import ihdp_pkg::*;

  phase_t      ph;
  logic [4:0]  pos;
  logic [15:0] seg_left;
  logic [7:0]  len_hi;
  logic [7:0]  marker;
  fmt_t        fmt;
  logic [31:0] width_acc;
  logic [31:0] height_acc;
  logic        dims_ok;
  out_beat_t   dims_expected[$];

  function automatic logic starts_frame(input logic [7:0] m);
    return (m >= MK_SOF_LO) && (m <= MK_SOF_HI) &&
           (m != MK_DHT) && (m != MK_JPG) && (m != MK_DAC);
  endfunction

  function automatic logic no_length(input logic [7:0] m);
    return (m == MK_TEM) || (m == MK_SOI) || (m == MK_EOI) ||
           ((m >= MK_RST0) && (m <= MK_RST7));
  endfunction

  task automatic clear_parse();
    ph = PH_SNIFF;
    pos = '0;
    seg_left = '0;
    len_hi = '0;
    marker = '0;
    fmt = FMT_NONE;
    width_acc = '0;
    height_acc = '0;
    dims_ok = 1'b0;
  endtask

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    logic [15:0] seg;
    out_beat_t   res;
    if (ph != PH_DONE) begin
      case (ph)
        PH_SNIFF: begin
          if (b == PNG_SIG[0]) ph = PH_PNG;
          else if (b == GIF_G) ph = PH_GIF;
          else if (b == MK_FILL) ph = PH_JSIG;
          else ph = PH_DONE;
        end
        PH_PNG: begin
          if (pos < 5'd8) begin
            if (b != PNG_SIG[pos]) ph = PH_DONE;
            else if (pos == 5'd7) fmt = FMT_PNG;
          end else if (pos >= 5'd12 && pos < 5'd16) begin
            if (b != IHDR_TAG[pos - 5'd12]) ph = PH_DONE;
          end else if (pos >= 5'd16 && pos < 5'd20) begin
            width_acc = {width_acc[23:0], b};
          end else if (pos >= 5'd20) begin
            height_acc = {height_acc[23:0], b};
            if (pos >= 5'd23) begin
              dims_ok = (width_acc != '0) && (height_acc != '0);
              ph = PH_DONE;
            end
          end
        end
        PH_GIF: begin
          case (pos)
            5'd1: if (b != GIF_I) ph = PH_DONE;
            5'd2: if (b != GIF_F) ph = PH_DONE;
            5'd3: if (b != GIF_8) ph = PH_DONE;
            5'd4: if (b != GIF_7 && b != GIF_9) ph = PH_DONE;
            5'd5: begin
              if (b != GIF_A) ph = PH_DONE;
              else fmt = FMT_GIF;
            end
            5'd6: width_acc = {24'd0, b};
            5'd7: width_acc = width_acc | {16'd0, b, 8'd0};
            5'd8: height_acc = {24'd0, b};
            5'd9: begin
              height_acc = height_acc | {16'd0, b, 8'd0};
              dims_ok = 1'b1;
              ph = PH_DONE;
            end
            default: ph = PH_DONE;
          endcase
        end
        PH_JSIG: begin
          if (pos == 5'd1) begin
            if (b != MK_SOI) ph = PH_DONE;
          end else if (pos == 5'd2 && b == MK_FILL) begin
            fmt = FMT_JPEG;
            ph = PH_JFILL;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_JMARK: ph = (b == MK_FILL) ? PH_JFILL : PH_DONE;
        PH_JFILL: begin
          if (b != MK_FILL) begin
            marker = b;
            if (b == MK_NONE || b == MK_SOS) ph = PH_DONE;
            else if (no_length(b)) ph = PH_JMARK;
            else ph = PH_JLENHI;
          end
        end
        PH_JLENHI: begin
          len_hi = b;
          ph = PH_JLENLO;
        end
        PH_JLENLO: begin
          seg = {len_hi, b};
          if (seg < 16'd2) begin
            ph = PH_DONE;
          end else if (starts_frame(marker)) begin
            if (seg < 16'd8) begin
              ph = PH_DONE;
            end else begin
              seg_left = '0;
              ph = PH_JSOF;
            end
          end else begin
            seg_left = seg - 16'd2;
            ph = (seg_left == '0) ? PH_JMARK : PH_JSKIP;
          end
        end
        PH_JSKIP: begin
          seg_left = seg_left - 16'd1;
          if (seg_left == '0) ph = PH_JMARK;
        end
        PH_JSOF: begin
          if (seg_left == 16'd4) begin
            width_acc = width_acc | {24'd0, b};
            dims_ok = 1'b1;
            ph = PH_DONE;
          end else begin
            if (seg_left == 16'd1) height_acc = {16'd0, b, 8'd0};
            else if (seg_left == 16'd2) height_acc = height_acc | {24'd0, b};
            else if (seg_left == 16'd3) width_acc = {16'd0, b, 8'd0};
            seg_left = seg_left + 16'd1;
          end
        end
        default: ph = PH_DONE;
      endcase
    end
    if (pos < OFF_MAX) pos = pos + 5'd1;

    if (lst) begin
      res.dims_valid = dims_ok;
      res.image_format = fmt;
      res.natural_width = dims_ok ? width_acc : 32'd0;
      res.natural_height = dims_ok ? height_acc : 32'd0;
      dims_expected.push_back(res);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      clear_parse();
      dims_expected.delete();
    end else begin
      if (in_valid && !in_stall) parse_byte(in_data.byte_value, in_data.last_byte);
      if (out_valid && !out_stall) begin
        if (dims_expected.size() == 0) begin
          note_mismatch($sformatf("result beat with no body pending (format %0d)",
                                  out_data.image_format));
        end else begin
          want = dims_expected.pop_front();
          results_checked++;
          if (want.dims_valid) dims_reported++;
          if (out_data.dims_valid !== want.dims_valid)
            note_mismatch($sformatf("dims_valid %b, expected %b",
                                    out_data.dims_valid, want.dims_valid));
          if (out_data.image_format !== want.image_format)
            note_mismatch($sformatf("image_format %0d, expected %0d",
                                    out_data.image_format, want.image_format));
          if (out_data.natural_width !== want.natural_width)
            note_mismatch($sformatf("natural_width %0h, expected %0h",
                                    out_data.natural_width, want.natural_width));
          if (out_data.natural_height !== want.natural_height)
            note_mismatch($sformatf("natural_height %0h, expected %0h",
                                    out_data.natural_height, want.natural_height));
        end
      end
    end
    dims_pending <= dims_expected.size();
  end

endmodule

/* verif/image_header_dimension_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image header dimension parser testbench
// Feeds the parser whole image bodies one byte beat at a time: a directed set
// of headers for each format and each refusal, then random PNG, GIF and JPEG
// headers with random content, mixed with noise, foreign formats, corrupted
// and truncated bodies. Both sides pause at random. The checker beside the
// parser predicts and compares every result.
// ----------------------------------------------------------------------------
module image_header_dimension_parser_tb;
  import ihdp_pkg::*;

  localparam logic [7:0] MK_APP0 = 8'hE0;
  localparam logic [7:0] MK_DQT  = 8'hDB;
  localparam logic [7:0] MK_COM  = 8'hFE;
  localparam int RANDOM_BYTES = 180;
  localparam int QUIET_LIMIT  = 1000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int mismatches;
  int dims_pending;
  int results_checked;
  int dims_reported;

  logic [7:0] body[$];
  int  bytes_sent = 0;
  int  bodies_sent = 0;
  int  png_built = 0;
  int  gif_built = 0;
  int  jpeg_built = 0;
  int  other_built = 0;
  bit  feed_calm = 1'b0;
  bit  sink_calm = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  always #6 clk = ~clk;

  image_header_dimension_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ihdp_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .dims_pending    (dims_pending),
    .results_checked (results_checked),
    .dims_reported   (dims_reported)
  );

  function automatic int draw_pause(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
  endfunction

  task automatic put_noise(input int n);
    repeat (n) body.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_marker(input logic [7:0] mk);
    body.push_back(MK_FILL);
    body.push_back(mk);
  endtask

  task automatic put_segment(input logic [7:0] mk, input logic [15:0] len);
    put_marker(mk);
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    if (len > 16'd2) put_noise(len - 2);
  endtask

  task automatic put_sof(input logic [7:0] mk, input logic [15:0] h, input logic [15:0] w);
    int len;
    len = 8 + $urandom_range(0, 9);
    put_marker(mk);
    body.push_back(8'd0);
    body.push_back(len[7:0]);
    body.push_back(8'd8);
    body.push_back(h[15:8]);
    body.push_back(h[7:0]);
    body.push_back(w[15:8]);
    body.push_back(w[7:0]);
    put_noise(len - 7);
  endtask

  task automatic put_png(input logic [31:0] w, input logic [31:0] h);
    for (int i = 0; i < 8; i++) body.push_back(PNG_SIG[i]);
    body.push_back(8'h00);
    body.push_back(8'h00);
    body.push_back(8'h00);
    body.push_back(8'h0D);
    for (int i = 0; i < 4; i++) body.push_back(IHDR_TAG[i]);
    for (int i = 3; i >= 0; i--) body.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) body.push_back(h[8*i +: 8]);
  endtask

  task automatic put_gif(input logic [7:0] ver, input logic [15:0] w, input logic [15:0] h);
    body.push_back(GIF_G);
    body.push_back(GIF_I);
    body.push_back(GIF_F);
    body.push_back(GIF_8);
    body.push_back(ver);
    body.push_back(GIF_A);
    body.push_back(w[7:0]);
    body.push_back(w[15:8]);
    body.push_back(h[7:0]);
    body.push_back(h[15:8]);
  endtask

  task automatic trim_body(input int n);
    while (body.size() > n) body.delete(body.size() - 1);
  endtask

  task automatic send_body();
    int gap;
    foreach (body[i]) begin
      gap = draw_pause(feed_calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= '{byte_value: body[i], last_byte: (i == body.size() - 1)};
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    bytes_sent += body.size();
    bodies_sent++;
    body.delete();
    feed_calm = ($urandom_range(0, 4) == 0);
  endtask

  always @(posedge clk) begin : result_pacing
    int pause;
    if (out_valid && !out_stall) begin
      pause = draw_pause(sink_calm);
      sink_calm = ($urandom_range(0, 4) == 0);
      stall_left <= pause;
      out_stall <= (pause != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timed out after %0d cycles without a beat.", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_start;
    logic [7:0] mk;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    body.push_back(8'h00);
    send_body();
    body.push_back(MK_FILL);
    send_body();
    put_png(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_body();
    put_png(32'd0, 32'd1);
    send_body();
    put_png(32'd1, 32'd0);
    put_noise(3);
    send_body();
    put_png(32'd5, 32'd5);
    body[13] = 8'h00;
    send_body();
    put_png(32'd7, 32'd7);
    trim_body(8);
    send_body();
    put_gif(GIF_7, 16'hFFFF, 16'h0000);
    put_noise(3);
    send_body();
    put_gif(GIF_9, 16'h0000, 16'hFFFF);
    send_body();
    put_gif(GIF_8, 16'd10, 16'd10);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_APP0, 16'd16);
    body.push_back(MK_FILL);
    put_segment(MK_DHT, 16'd6);
    put_segment(MK_JPG, 16'd2);
    put_segment(MK_DAC, 16'd3);
    put_sof(MK_SOF_LO, 16'hFFFF, 16'hFFFF);
    send_body();
    put_marker(MK_SOI);
    put_marker(MK_RST0);
    put_marker(MK_TEM);
    put_marker(MK_EOI);
    put_marker(MK_RST7);
    put_marker(MK_SOI);
    put_sof(MK_SOF_HI, 16'd1, 16'd0);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_SOS, 16'd4);
    send_body();
    put_marker(MK_SOI);
    put_marker(MK_NONE);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_APP0, 16'd1);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_SOF_LO, 16'd7);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_APP0, 16'd4);
    body.push_back(8'h12);
    put_sof(MK_SOF_LO, 16'd3, 16'd3);
    send_body();
    put_marker(MK_SOI);
    body.push_back(8'h00);
    send_body();
    put_marker(MK_EOI);
    body.push_back(MK_FILL);
    send_body();
    body.push_back(8'h42);
    body.push_back(8'h4D);
    put_noise(10);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_COM, 16'h0105);
    put_sof(8'hC2, 16'h1234, 16'h5678);
    send_body();
    put_marker(MK_SOI);
    put_segment(MK_DQT, 16'd12);
    trim_body(9);
    send_body();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          put_png(($urandom_range(0, 7) == 0) ? 32'd0 : $urandom(),
                  ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 4096));
          put_noise($urandom_range(0, 4));
          png_built++;
        end
        3, 4: begin
          put_gif(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                  (($urandom_range(0, 1) == 0) ? GIF_7 : GIF_9),
                  16'($urandom()), 16'($urandom()));
          put_noise($urandom_range(0, 4));
          gif_built++;
        end
        5, 6, 7: begin
          put_marker(MK_SOI);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0) body.push_back(MK_FILL);
            if ($urandom_range(0, 3) == 0) put_marker(MK_RST0 + 8'($urandom_range(0, 7)));
            case ($urandom_range(0, 4))
              0: mk = MK_DHT;
              1: mk = MK_DQT;
              2: mk = MK_COM;
              default: mk = MK_APP0 + 8'($urandom_range(0, 15));
            endcase
            put_segment(mk, 16'($urandom_range(2, 12)));
          end
          put_sof(MK_SOF_LO + 8'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()));
          jpeg_built++;
        end
        8: begin
          body.push_back(8'h52);
          body.push_back(8'h49);
          body.push_back(8'h46);
          body.push_back(8'h46);
          put_noise(4);
          body.push_back(8'h57);
          body.push_back(8'h45);
          body.push_back(8'h42);
          body.push_back(8'h50);
          put_noise($urandom_range(0, 6));
          other_built++;
        end
        default: begin
          put_noise($urandom_range(1, 30));
          other_built++;
        end
      endcase
      if ($urandom_range(0, 5) == 0)
        body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) trim_body($urandom_range(1, body.size()));
      send_body();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (dims_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d bytes in %0d bodies; random part built %0d PNG, %0d GIF, %0d JPEG, %0d other.",
             bytes_sent, bodies_sent, png_built, gif_built, jpeg_built, other_built);
    $display("Compared %0d results, %0d carrying dimensions; %0d mismatches.",
             results_checked, dims_reported, mismatches);
    if (mismatches == 0 && dims_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
